// ----- hw/rtl/dsu_pkg.sv -----
// Shared types and constants of the disjoint-set union-find block.
package dsu_pkg;

    localparam int NODE_W = 10;
    localparam int SIZE_W = 11;
    localparam int REQ_W  = 2;
    localparam int IN_W   = 24;
    localparam int OUT_W  = 24;
    localparam int ST_W   = 3;

    localparam logic [SIZE_W-1:0] NODE_COUNT_RST = 11'd1024;
    localparam logic [SIZE_W-1:0] SIZE_ONE       = 11'd1;

    localparam logic [REQ_W-1:0] REQ_UNITE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FIND   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REINIT = 2'd2;

    localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
    localparam logic [ST_W-1:0] ST_CLR  = 3'd1;
    localparam logic [ST_W-1:0] ST_F_RD = 3'd2;
    localparam logic [ST_W-1:0] ST_F_UP = 3'd3;
    localparam logic [ST_W-1:0] ST_C_RD = 3'd4;
    localparam logic [ST_W-1:0] ST_C_WR = 3'd5;
    localparam logic [ST_W-1:0] ST_LINK = 3'd6;
    localparam logic [ST_W-1:0] ST_PUT  = 3'd7;

    typedef struct packed {
        logic              pad;
        logic              bad_node;
        logic              merged;
        logic [SIZE_W-1:0] set_size;
        logic [NODE_W-1:0] root;
    } t_result;

endpackage

// ----- hw/rtl/disjoint_set_union_find.sv -----
// Disjoint-set union-find table: union by size, full path compression.
//
// Requests arrive on the slave stream: tuser carries the request kind
// (unite, find, reinitialise), tdata carries node_a and node_b. Every
// request gives exactly one result beat on the master stream: root,
// set size, merged flag and bad-node flag.
// Parent and size entries live in two single-port-write memories with a
// registered read. A find walks the parent chain one memory read per
// hop, then rewrites the path one entry at a time, each with a read and
// then a write. A bad index or an unknown kind skips the memories and
// goes straight to loading its result. Reinitialise sweeps all NODES
// entries, one a cycle, and then loads its result. The next request can
// be taken in the cycle after a result is loaded. After reset the block
// sweeps all NODES entries with s_tready low; configuration writes are
// taken throughout. The result sits in an output register: the engine
// runs on while the receiver stalls and holds only when a second result
// is ready before the first beat has been taken. One request is in
// flight at a time.
module disjoint_set_union_find #(
    parameter int NODES = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [dsu_pkg::IN_W-1:0] i_s_tdata,   // node_a[9:0], node_b[19:10], zero
    input  logic [dsu_pkg::REQ_W-1:0] i_s_tuser,  // req_type[1:0]
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [dsu_pkg::OUT_W-1:0] o_m_tdata,  // root[9:0], set_size[20:10],
                                                  // merged[21], bad_node[22], zero
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [dsu_pkg::SIZE_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(NODES);
    localparam logic [AW-1:0] LAST = AW'(NODES - 1);
    localparam int SW = dsu_pkg::SIZE_W;
    localparam int NW = dsu_pkg::NODE_W;

    logic [AW-1:0] r_parent_mem [NODES];
    logic [SW-1:0] r_size_mem [NODES];
    logic [AW-1:0] r_pq;
    logic [SW-1:0] r_sq;

    logic [dsu_pkg::ST_W-1:0]  r_state, n_state;
    logic                      r_second, n_second;
    logic                      r_clr_put, n_clr_put;
    logic [dsu_pkg::REQ_W-1:0] r_kind, n_kind;
    logic [AW-1:0]             r_b, n_b;
    logic [AW-1:0]             r_cur, n_cur;
    logic [AW-1:0]             r_start, n_start;
    logic [AW-1:0]             r_root, n_root;
    logic [SW-1:0]             r_rsz, n_rsz;
    logic [AW-1:0]             r_ra, n_ra;
    logic [SW-1:0]             r_sa, n_sa;
    logic [AW-1:0]             r_cnt, n_cnt;
    logic [SW-1:0]             r_node_count, n_node_count;
    logic                      r_ovalid, n_ovalid;
    dsu_pkg::t_result          r_res, n_res;
    dsu_pkg::t_result          r_odata, n_odata;

    logic [AW-1:0] rd_addr;
    logic          p_we;
    logic [AW-1:0] p_wa;
    logic [AW-1:0] p_wd;
    logic          s_we;
    logic [AW-1:0] s_wa;
    logic [SW-1:0] s_wd;

    logic [NW-1:0] in_a;
    logic [NW-1:0] in_b;
    logic          a_bad;
    logic          b_bad;
    logic [SW-1:0] sum_sz;

    assign in_a = i_s_tdata[NW-1:0];
    assign in_b = i_s_tdata[2*NW-1:NW];
    assign a_bad = (SW'(in_a) >= r_node_count) || (32'(in_a) >= NODES);
    assign b_bad = (SW'(in_b) >= r_node_count) || (32'(in_b) >= NODES);
    assign sum_sz = r_sa + r_rsz;

    assign o_s_tready  = (r_state == dsu_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = r_odata;

    always_ff @(posedge i_clk) begin
        if (p_we) begin
            r_parent_mem[p_wa] <= p_wd;
        end
        r_pq <= r_parent_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_size_mem[s_wa] <= s_wd;
        end
        r_sq <= r_size_mem[rd_addr];
    end

    always_comb begin
        n_state      = r_state;
        n_second     = r_second;
        n_clr_put    = r_clr_put;
        n_kind       = r_kind;
        n_b          = r_b;
        n_cur        = r_cur;
        n_start      = r_start;
        n_root       = r_root;
        n_rsz        = r_rsz;
        n_ra         = r_ra;
        n_sa         = r_sa;
        n_cnt        = r_cnt;
        n_res        = r_res;
        n_odata      = r_odata;
        n_ovalid     = r_ovalid;
        n_node_count = r_node_count;
        rd_addr      = r_cur;
        p_we         = 1'b0;
        p_wa         = r_cur;
        p_wd         = r_root;
        s_we         = 1'b0;
        s_wa         = r_cur;
        s_wd         = dsu_pkg::SIZE_ONE;

        if (i_cfg_valid) begin
            n_node_count = i_cfg_data;
        end
        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            dsu_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_kind   = i_s_tuser;
                    n_b      = AW'(in_b);
                    n_cur    = AW'(in_a);
                    n_start  = AW'(in_a);
                    n_second = 1'b0;
                    n_res    = '0;
                    case (i_s_tuser)
                        dsu_pkg::REQ_UNITE: begin
                            if (a_bad || b_bad) begin
                                n_res.bad_node = 1'b1;
                                n_state        = dsu_pkg::ST_PUT;
                            end else begin
                                n_state = dsu_pkg::ST_F_RD;
                            end
                        end
                        dsu_pkg::REQ_FIND: begin
                            if (a_bad) begin
                                n_res.bad_node = 1'b1;
                                n_state        = dsu_pkg::ST_PUT;
                            end else begin
                                n_state = dsu_pkg::ST_F_RD;
                            end
                        end
                        dsu_pkg::REQ_REINIT: begin
                            n_res.root     = in_a;
                            n_res.set_size = dsu_pkg::SIZE_ONE;
                            n_cnt          = '0;
                            n_clr_put      = 1'b1;
                            n_state        = dsu_pkg::ST_CLR;
                        end
                        default: begin
                            n_state = dsu_pkg::ST_PUT;
                        end
                    endcase
                end
            end
            dsu_pkg::ST_CLR: begin
                p_we = 1'b1;
                p_wa = r_cnt;
                p_wd = r_cnt;
                s_we = 1'b1;
                s_wa = r_cnt;
                s_wd = dsu_pkg::SIZE_ONE;
                n_cnt = r_cnt + AW'(1);
                if (r_cnt == LAST) begin
                    n_state = r_clr_put ? dsu_pkg::ST_PUT : dsu_pkg::ST_IDLE;
                end
            end
            dsu_pkg::ST_F_RD: begin
                n_state = dsu_pkg::ST_F_UP;
            end
            dsu_pkg::ST_F_UP: begin
                if (r_pq == r_cur) begin
                    n_root  = r_cur;
                    n_rsz   = r_sq;
                    n_cur   = r_start;
                    n_state = dsu_pkg::ST_C_RD;
                end else begin
                    rd_addr = r_pq;
                    n_cur   = r_pq;
                end
            end
            dsu_pkg::ST_C_RD: begin
                if (r_cur != r_root) begin
                    n_state = dsu_pkg::ST_C_WR;
                end else if (r_second) begin
                    n_state = dsu_pkg::ST_LINK;
                end else if (r_kind == dsu_pkg::REQ_FIND) begin
                    n_res.root     = NW'(r_root);
                    n_res.set_size = r_rsz;
                    n_state        = dsu_pkg::ST_PUT;
                end else begin
                    n_ra     = r_root;
                    n_sa     = r_rsz;
                    n_second = 1'b1;
                    n_start  = r_b;
                    n_cur    = r_b;
                    n_state  = dsu_pkg::ST_F_RD;
                end
            end
            dsu_pkg::ST_C_WR: begin
                p_we    = 1'b1;
                n_cur   = r_pq;
                n_state = dsu_pkg::ST_C_RD;
            end
            dsu_pkg::ST_LINK: begin
                if (r_ra == r_root) begin
                    n_res.root     = NW'(r_ra);
                    n_res.set_size = r_sa;
                end else begin
                    s_we           = 1'b1;
                    s_wd           = sum_sz;
                    p_we           = 1'b1;
                    n_res.merged   = 1'b1;
                    n_res.set_size = sum_sz;
                    if (r_sa < r_rsz) begin
                        s_wa       = r_root;
                        p_wa       = r_ra;
                        p_wd       = r_root;
                        n_res.root = NW'(r_root);
                    end else begin
                        s_wa       = r_ra;
                        p_wa       = r_root;
                        p_wd       = r_ra;
                        n_res.root = NW'(r_ra);
                    end
                end
                n_state = dsu_pkg::ST_PUT;
            end
            dsu_pkg::ST_PUT: begin
                if (!r_ovalid || i_m_tready) begin
                    n_odata  = r_res;
                    n_ovalid = 1'b1;
                    n_state  = dsu_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dsu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= dsu_pkg::ST_CLR;
            r_cnt        <= '0;
            r_clr_put    <= 1'b0;
            r_second     <= 1'b0;
            r_ovalid     <= 1'b0;
            r_node_count <= dsu_pkg::NODE_COUNT_RST;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_clr_put    <= n_clr_put;
            r_second     <= n_second;
            r_ovalid     <= n_ovalid;
            r_node_count <= n_node_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_b     <= n_b;
        r_cur   <= n_cur;
        r_start <= n_start;
        r_root  <= n_root;
        r_rsz   <= n_rsz;
        r_ra    <= n_ra;
        r_sa    <= n_sa;
        r_res   <= n_res;
        r_odata <= n_odata;
    end

endmodule
